>>> rtl/core/pidc_pkg.sv
package pidc_pkg;

	localparam int CfgIdxW = 3;
	localparam int DataW   = 32;
	localparam int DtW     = 16;
	localparam int NumW    = 49;
	localparam int SumW    = 50;

	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_DRIVE_LOW  = 3'd3,
		REG_DRIVE_HIGH = 3'd4,
		REG_ACCUM_LOW  = 3'd5,
		REG_ACCUM_HIGH = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_ERR_DT = 2'd0,
		MUL_P      = 2'd1,
		MUL_I      = 2'd2,
		MUL_D      = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     calc_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     div_start;
		logic     acc_update;
		logic     sum_load;
		logic     sum_add;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic dt_zero;
		logic div_busy;
		logic out_hold;
	} stat_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] v);
		logic signed [SumW-1:0] vmax;
		logic signed [SumW-1:0] vmin;
		vmax = 50'sd2147483647;
		vmin = -50'sd2147483648;
		if (v > vmax)
			return 32'h7fff_ffff;
		else if (v < vmin)
			return 32'h8000_0000;
		else
			return v[DataW-1:0];
	endfunction

	function automatic logic signed [DataW-1:0] clamp32(input logic signed [DataW-1:0] v,
		input logic signed [DataW-1:0] lo, input logic signed [DataW-1:0] hi);
		logic signed [DataW-1:0] r;
		r = v;
		if (r > hi)
			r = hi;
		if (r < lo)
			r = lo;
		return r;
	endfunction

endpackage

>>> rtl/core/pid_controller_clamped_top.sv
// Clamped PID controller, signed Q16.16.
// Input channel (in_valid/in_ready) takes one request of target, measured and
// step_time; output channel (out_valid/out_ready) returns one drive value per
// request, in order. Configuration registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no request
// is in flight, which the block does not enforce. Index 7 is ignored.
// A request with step_time zero returns 0 and leaves state as is.
// One request at a time is in flight, paced by the 49-step restoring divider
// for the derivative; the one shared 32x32 multiplier runs in its shadow.
// The next request is accepted while a result still waits in the output
// register; a stalled receiver holds the controller in its final step until
// the waiting result is taken.
// Reset clears gains, limits, integral and last error to zero, empties the
// output register and returns the controller to idle.
module pid_controller_clamped_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pidc_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [pidc_pkg::DataW-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [pidc_pkg::DataW-1:0]   target,
	input  logic signed [pidc_pkg::DataW-1:0]   measured,
	input  logic [pidc_pkg::DtW-1:0]            step_time,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pidc_pkg::DataW-1:0]   drive
);
	import pidc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pidc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pidc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.target    (target),
		.measured  (measured),
		.step_time (step_time),
		.drive     (drive),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && !out_ready))
		else $error("result register overwritten while stalled");

	a_div_valid_dt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.dt_zero)
		else $error("divider started with zero step time");

	a_div_done_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_en && cmd.mul_sel == MUL_D |-> !stat.div_busy)
		else $error("derivative used before divider finished");

endmodule

>>> rtl/core/pidc_div.sv
module pidc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pidc_pkg::NumW-1:0]         num,
	input  logic [pidc_pkg::DtW-1:0]          den,
	input  logic                              neg,
	output logic                              busy,
	output logic signed [pidc_pkg::DataW-1:0] quot
);
	import pidc_pkg::*;

	localparam int CntW = $clog2(NumW + 1);

	logic [CntW-1:0] cnt_q;
	logic [DtW-1:0]  rem_q;
	logic [DtW-1:0]  den_q;
	logic [NumW-1:0] quo_q;
	logic            neg_q;
	logic [DtW:0]    trial;
	logic            fits;

	assign trial = {rem_q, quo_q[NumW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = cnt_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (start)
			cnt_q <= CntW'(NumW);
		else if (busy)
			cnt_q <= cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
			neg_q <= neg;
		end else if (busy) begin
			rem_q <= fits ? DtW'(trial - {1'b0, den_q}) : trial[DtW-1:0];
			quo_q <= {quo_q[NumW-2:0], fits};
		end
	end

	always_comb begin
		if (neg_q) begin
			if ((|quo_q[NumW-1:DataW]) || (quo_q[DataW-1] && (|quo_q[DataW-2:0])))
				quot = 32'h8000_0000;
			else
				quot = -quo_q[DataW-1:0];
		end else begin
			if (|quo_q[NumW-1:DataW-1])
				quot = 32'h7fff_ffff;
			else
				quot = quo_q[DataW-1:0];
		end
	end

endmodule

>>> rtl/core/pidc_dpath.sv
module pidc_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pidc_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [pidc_pkg::DataW-1:0]          cfg_data,
	input  logic signed [pidc_pkg::DataW-1:0]   target,
	input  logic signed [pidc_pkg::DataW-1:0]   measured,
	input  logic [pidc_pkg::DtW-1:0]            step_time,
	output logic signed [pidc_pkg::DataW-1:0]   drive,
	output logic                                out_valid,
	input  logic                                out_ready,
	input  pidc_pkg::cmd_t                      cmd,
	output pidc_pkg::stat_t                     stat
);
	import pidc_pkg::*;

	logic signed [DataW-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [DataW-1:0] drive_low_q, drive_high_q, accum_low_q, accum_high_q;
	logic signed [DataW-1:0] target_q, measured_q, err_q;
	logic [DtW-1:0]          dt_q;
	logic signed [DataW-1:0] accum_q, last_error_q;
	logic signed [63:0]      prod_q;
	logic signed [SumW-1:0]  sum_q;
	logic signed [DataW-1:0] drive_q;
	logic                    out_valid_q;

	logic signed [DataW:0]   err_diff;
	logic signed [SumW-1:0]  err_ext;
	logic signed [DataW-1:0] mul_a, mul_b;
	logic signed [SumW-1:0]  term;
	logic signed [SumW-1:0]  acc_sum;
	logic signed [DataW+1:0] d_diff;
	logic [DataW+1:0]        d_mag;
	logic signed [DataW-1:0] deriv;
	logic                    div_busy;
	logic signed [DataW-1:0] fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			drive_low_q  <= '0;
			drive_high_q <= '0;
			accum_low_q  <= '0;
			accum_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P:     gain_p_q     <= cfg_data;
				REG_GAIN_I:     gain_i_q     <= cfg_data;
				REG_GAIN_D:     gain_d_q     <= cfg_data;
				REG_DRIVE_LOW:  drive_low_q  <= cfg_data;
				REG_DRIVE_HIGH: drive_high_q <= cfg_data;
				REG_ACCUM_LOW:  accum_low_q  <= cfg_data;
				REG_ACCUM_HIGH: accum_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign err_diff = {target_q[DataW-1], target_q} - {measured_q[DataW-1], measured_q};
	assign err_ext  = {{(SumW-DataW-1){err_diff[DataW]}}, err_diff};

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_ERR_DT: begin
				mul_a = err_q;
				mul_b = {{(DataW-DtW){1'b0}}, dt_q};
			end
			MUL_P: begin
				mul_a = gain_p_q;
				mul_b = err_q;
			end
			MUL_I: begin
				mul_a = gain_i_q;
				mul_b = accum_q;
			end
			MUL_D: begin
				mul_a = gain_d_q;
				mul_b = deriv;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign term    = {{2{prod_q[63]}}, prod_q[63:16]};
	assign acc_sum = {{(SumW-DataW){accum_q[DataW-1]}}, accum_q} + term;

	assign d_diff = {{2{err_q[DataW-1]}}, err_q} - {{2{last_error_q[DataW-1]}}, last_error_q};
	assign d_mag  = d_diff[DataW+1] ? -d_diff : d_diff;

	pidc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({d_mag[DataW:0], {DtW{1'b0}}}),
		.den    (dt_q),
		.neg    (d_diff[DataW+1]),
		.busy   (div_busy),
		.quot   (deriv)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			target_q   <= target;
			measured_q <= measured;
			dt_q       <= step_time;
		end
		if (cmd.calc_err)
			err_q <= sat32(err_ext);
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.sum_load)
			sum_q <= term;
		else if (cmd.sum_add)
			sum_q <= sum_q + term;
		if (cmd.out_load)
			drive_q <= fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q      <= '0;
			last_error_q <= '0;
		end else if (cmd.acc_update) begin
			accum_q      <= clamp32(sat32(acc_sum), accum_low_q, accum_high_q);
			last_error_q <= err_q;
		end
	end

	assign fin = (dt_q == '0) ? '0 : clamp32(sat32(sum_q), drive_low_q, drive_high_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign drive     = drive_q;
	assign out_valid = out_valid_q;

	assign stat.dt_zero  = dt_q == '0;
	assign stat.div_busy = div_busy;
	assign stat.out_hold = out_valid_q & ~out_ready;

endmodule

>>> rtl/core/pidc_ctrl.sv
module pidc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pidc_pkg::stat_t stat,
	output pidc_pkg::cmd_t  cmd
);
	import pidc_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_CHECK    = 9'b000000010,
		ST_MUL_A    = 9'b000000100,
		ST_ACC      = 9'b000001000,
		ST_MUL_I    = 9'b000010000,
		ST_ADD_I    = 9'b000100000,
		ST_WAIT_DIV = 9'b001000000,
		ST_ADD_D    = 9'b010000000,
		ST_DONE     = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.dt_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.calc_err = 1'b1;
					state_d      = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_ERR_DT;
				cmd.div_start = 1'b1;
				state_d       = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_update = 1'b1;
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = MUL_P;
				state_d        = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.sum_load = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_I;
				state_d      = ST_ADD_I;
			end
			ST_ADD_I: begin
				cmd.sum_add = 1'b1;
				state_d     = ST_WAIT_DIV;
			end
			ST_WAIT_DIV: begin
				if (!stat.div_busy) begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_D;
					state_d     = ST_ADD_D;
				end
			end
			ST_ADD_D: begin
				cmd.sum_add = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.out_hold) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> tb/pid_controller_clamped_top_tb.sv
`timescale 1ns / 100ps

module pid_controller_clamped_top_tb;
	import pidc_pkg::*;

	localparam int NumRegs = int'(REG_ACCUM_HIGH) + 1;
	localparam logic [CfgIdxW-1:0] REG_NONE = 3'd7;
	localparam logic [DataW-1:0] DMax = 32'h7fff_ffff;
	localparam logic [DataW-1:0] DMin = 32'h8000_0000;
	localparam logic [DataW-1:0] QOne = 32'h0001_0000;

	typedef logic [NumRegs-1:0][DataW-1:0] gain_set_t;

	typedef struct packed {
		logic [2:0]       preset;
		logic [DataW-1:0] tgt;
		logic [DataW-1:0] meas;
		logic [DtW-1:0]   dt;
		logic             pinned;
		logic [DataW-1:0] want;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CfgIdxW-1:0]      cfg_index = '0;
	logic [DataW-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [DataW-1:0] target = '0;
	logic signed [DataW-1:0] measured = '0;
	logic [DtW-1:0]          step_time = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [DataW-1:0] drive;

	gain_set_t               cfg_now = '0;
	longint                  integ_m = 0;
	longint                  prev_err_m = 0;
	logic signed [DataW-1:0] drive_due[$];
	logic signed [DataW-1:0] drive_head;
	int                      bad_count = 0;
	int                      hold_left = 0;
	bit                      calm = 1'b0;
	gain_set_t               presets[6];
	stim_row_t               steps[$];

	pid_controller_clamped_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.target    (target),
		.measured  (measured),
		.step_time (step_time),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#1000000;
		$display("pid_controller_clamped_top_tb: FAIL");
		$finish;
	end

	function automatic longint saturate32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v;
	endfunction

	function automatic logic signed [DataW-1:0] predict_drive(input logic signed [DataW-1:0] t,
		input logic signed [DataW-1:0] m, input logic [DtW-1:0] dt);
		longint tl, ml, dtl, err, der, total;
		longint kp, ki, kd, dlo, dhi, alo, ahi;
		if (dt == '0)
			return '0;
		tl  = t;
		ml  = m;
		dtl = dt;
		kp  = $signed(cfg_now[REG_GAIN_P]);
		ki  = $signed(cfg_now[REG_GAIN_I]);
		kd  = $signed(cfg_now[REG_GAIN_D]);
		dlo = $signed(cfg_now[REG_DRIVE_LOW]);
		dhi = $signed(cfg_now[REG_DRIVE_HIGH]);
		alo = $signed(cfg_now[REG_ACCUM_LOW]);
		ahi = $signed(cfg_now[REG_ACCUM_HIGH]);
		err = saturate32(tl - ml);
		integ_m = clip(saturate32(integ_m + ((err * dtl) >>> 16)), alo, ahi);
		der = saturate32(((err - prev_err_m) * 65536) / dtl);
		prev_err_m = err;
		total = ((kp * err) >>> 16) + ((ki * integ_m) >>> 16) + ((kd * der) >>> 16);
		return DataW'(clip(saturate32(total), dlo, dhi));
	endfunction

	function automatic gain_set_t mk_set(input logic [DataW-1:0] kp, ki, kd, dlo, dhi, alo, ahi);
		return {ahi, alo, dhi, dlo, kd, ki, kp};
	endfunction

	function automatic logic [DataW-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return DMax;
			1: return DMin;
			2: return '0;
			3, 4: return $urandom;
			default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
		endcase
	endfunction

	function automatic gain_set_t rand_set();
		gain_set_t s;
		logic [DataW-1:0] a, b;
		s[REG_GAIN_P] = pick_level();
		s[REG_GAIN_I] = pick_level();
		s[REG_GAIN_D] = pick_level();
		for (int k = 0; k < 2; k++) begin
			a = pick_level();
			b = pick_level();
			if ($urandom_range(0, 4) != 0 && $signed(a) > $signed(b)) begin
				s[int'(REG_DRIVE_LOW) + 2 * k]  = b;
				s[int'(REG_DRIVE_HIGH) + 2 * k] = a;
			end else begin
				s[int'(REG_DRIVE_LOW) + 2 * k]  = a;
				s[int'(REG_DRIVE_HIGH) + 2 * k] = b;
			end
		end
		return s;
	endfunction

	task automatic add_row(input logic [2:0] p, input logic [DataW-1:0] t, m,
		input logic [DtW-1:0] dt, input logic pin, input logic [DataW-1:0] want);
		steps.push_back({p, t, m, dt, pin, want});
	endtask

	task automatic set_regs(input gain_set_t s);
		for (int i = 0; i < NumRegs; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CfgIdxW'(i);
			cfg_data  <= s[i];
			@(posedge clk);
		end
		cfg_index <= REG_NONE;
		cfg_data  <= $urandom;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cfg_now = s;
	endtask

	task automatic wait_drained();
		if (in_valid)
			in_valid <= 1'b0;
		while (drive_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_request(input logic [DataW-1:0] t, m, input logic [DtW-1:0] dt,
		input logic pinned, input logic [DataW-1:0] want);
		int gap;
		logic signed [DataW-1:0] predicted;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		target    <= t;
		measured  <= m;
		step_time <= dt;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = predict_drive(t, m, dt);
		drive_due.push_back(pinned ? want : predicted);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (drive_due.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("drive %0d with no request pending", drive);
				end else begin
					drive_head = drive_due.pop_front();
					if (drive !== drive_head) begin
						bad_count++;
						if (bad_count <= 10)
							$display("drive mismatch: expected %0d, got %0d", drive_head, drive);
					end
				end
				hold_left = calm ? 0 : $urandom_range(0, 13);
				if (hold_left != 0)
					out_ready <= 1'b0;
			end else if (out_valid && !out_ready) begin
				if (hold_left == 0)
					out_ready <= 1'b1;
				else
					hold_left--;
			end
		end
	end

	initial begin
		stim_row_t r;
		int cur_preset, sent, run_len, kind;
		logic [DataW-1:0] home, t, m;
		logic [DtW-1:0] pace, dt;

		presets[0] = '0;
		presets[1] = mk_set(QOne, '0, '0, DMin, DMax, DMin, DMax);
		presets[2] = mk_set(DMax, DMin, DMax, DMin, DMax, DMin, DMax);
		presets[3] = mk_set(32'h0002_0000, 32'h0000_8000, 32'h0000_4000,
			32'hff9c_0000, 32'h0064_0000, 32'hffff_0000, QOne);
		presets[4] = mk_set(QOne, QOne, QOne, 32'h0005_0000, 32'hfffb_0000,
			32'h0002_0000, 32'hfffe_0000);
		presets[5] = mk_set(DMin, DMin, DMin, DMin, DMax, DMin, DMax);

		add_row(0, 32'h0005_0000, 32'h0002_0000, 16'h1000, 1'b1, '0);
		add_row(0, DMax, DMin, 16'hffff, 1'b1, '0);
		add_row(1, 32'h0003_0000, QOne, 16'h8000, 1'b1, 32'h0002_0000);
		add_row(1, DMax, DMin, 16'h0001, 1'b1, DMax);
		add_row(1, DMin, DMax, 16'hffff, 1'b1, DMin);
		add_row(1, DMax, '0, 16'h0000, 1'b1, '0);
		add_row(1, '0, QOne, 16'h0001, 1'b1, 32'hffff_0000);
		add_row(2, DMax, DMin, 16'hffff, 1'b0, '0);
		add_row(2, DMin, DMax, 16'h0001, 1'b0, '0);
		add_row(2, '0, '0, 16'h8000, 1'b0, '0);
		add_row(2, 32'h0000_0001, '0, 16'h0001, 1'b0, '0);
		add_row(2, 32'h1234_5678, 32'hffff_fffb, 16'h0000, 1'b1, '0);
		add_row(3, 32'h000a_0000, '0, 16'h4000, 1'b0, '0);
		add_row(3, 32'h000a_0000, '0, 16'h4000, 1'b0, '0);
		add_row(3, 32'h000a_0000, 32'h0009_0000, 16'h4000, 1'b0, '0);
		add_row(3, DMin, DMax, 16'hffff, 1'b0, '0);
		add_row(3, DMax, DMin, 16'h0001, 1'b0, '0);
		add_row(4, 32'h0003_0000, '0, 16'h8000, 1'b1, 32'h0005_0000);
		add_row(4, DMin, DMax, 16'hffff, 1'b1, 32'h0005_0000);
		add_row(4, DMax, DMin, 16'h0000, 1'b1, '0);
		add_row(5, DMax, DMin, 16'hffff, 1'b0, '0);
		add_row(5, DMin, DMax, 16'hffff, 1'b0, '0);
		add_row(5, 32'h0000_7fff, 32'hffff_8001, 16'h0001, 1'b0, '0);
		add_row(5, 32'h0001_0000, 32'h0002_0000, 16'h0000, 1'b1, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_preset = 0;
		for (int i = 0; i < steps.size(); i++) begin
			r = steps[i];
			if (r.preset != cur_preset) begin
				wait_drained();
				set_regs(presets[r.preset]);
				cur_preset = r.preset;
			end
			send_request(r.tgt, r.meas, r.dt, r.pinned, r.want);
		end

		sent = 0;
		while (sent < 400) begin
			wait_drained();
			set_regs(rand_set());
			calm = ($urandom_range(0, 3) == 0);
			home = pick_level();
			case ($urandom_range(0, 3))
				0: pace = 16'h0001;
				1: pace = 16'hffff;
				2: pace = DtW'($urandom_range(1, 16'hffff));
				default: pace = DtW'($urandom_range(16'h0040, 16'h1000));
			endcase
			run_len = $urandom_range(20, 50);
			repeat (run_len) begin
				kind = $urandom_range(0, 9);
				if ($urandom_range(0, 19) == 0)
					home = pick_level();
				t  = home;
				m  = home + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
				dt = pace;
				if (kind == 0) begin
					t  = $urandom;
					m  = $urandom;
					dt = DtW'($urandom);
				end else if (kind == 1) begin
					dt = '0;
				end
				send_request(t, m, dt, 1'b0, '0);
				sent++;
				if ($urandom_range(0, 29) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (64) @(posedge clk);
		if (bad_count == 0 && drive_due.size() == 0) begin
			$display("pid_controller_clamped_top_tb: PASS");
		end else begin
			$display("pid_controller_clamped_top_tb: FAIL");
		end
		$finish;
	end

endmodule
